// ----- rtl/core/klk_pkg.sv -----
// Shared types and constants for the keypad code lock.
package klk_pkg;

	localparam int KEY_W      = 4;
	localparam int STATUS_W   = 3;
	localparam int KEYS_W     = 3;
	localparam int LIMIT_W    = 4;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WRONG_LIMIT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 1'b1;

	localparam logic [LIMIT_W-1:0] WRONG_LIMIT_RESET   = 4'd4;
	localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RESET = 16'd10000;

	localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
	localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

	// Factory code 2 5 8 0, first key in the highest nibble.
	localparam logic [31:0] CODE_RESET = 32'h0000_2580;

	typedef enum logic [1:0] {
		MODE_ENTER,
		MODE_OPEN,
		MODE_NEWCODE
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE,
		ST_TAKEN,
		ST_UNLOCKED,
		ST_WRONG,
		ST_LOCKOUT,
		ST_RELOCKED,
		ST_NEWENTRY,
		ST_CHANGED
	} status_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] wrong_limit;
		logic [TICKS_W-1:0] lockout_ticks;
	} cfg_t;

	typedef struct packed {
		status_t             status;
		logic                latch_open;
		logic [KEYS_W-1:0]   keys_entered;
		logic                locked_out;
	} result_t;

endpackage

// ----- rtl/core/klk_in_if.sv -----
// Channel carrying key presses and timer ticks into the lock.
interface klk_in_if import klk_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             command;
	logic [KEY_W-1:0] key;

	modport source (output valid, output command, output key, input ready);
	modport sink (input valid, input command, input key, output ready);
endinterface

// ----- rtl/core/klk_out_if.sv -----
// Channel carrying one result per transaction out of the lock.
interface klk_out_if import klk_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                latch_open;
	logic [KEYS_W-1:0]   keys_entered;
	logic                locked_out;

	modport source (output valid, output status, output latch_open, output keys_entered,
		output locked_out, input ready);
	modport sink (input valid, input status, input latch_open, input keys_entered,
		input locked_out, output ready);
endinterface

// ----- rtl/core/klk_cfg.sv -----
// Configuration registers of the keypad code lock.
module klk_cfg import klk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wrong_limit   <= WRONG_LIMIT_RESET;
			cfg_q.lockout_ticks <= LOCKOUT_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WRONG_LIMIT: begin
					cfg_q.wrong_limit <= cfg_data[LIMIT_W-1:0];
				end
				REG_LOCKOUT_TICKS: begin
					cfg_q.lockout_ticks <= cfg_data[TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/klk_fsm.sv -----
// Lock state machine: code entry, compare, latch, code change and lockout.
module klk_fsm import klk_pkg::*; #(
	parameter int CODE_LENGTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             command,
	input  logic [KEY_W-1:0] key,
	input  cfg_t             cfg,
	output result_t          result
);

	localparam int CW   = KEY_W * CODE_LENGTH;
	localparam int CNTW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
	localparam logic [CNTW-1:0] LAST_KEY = CNTW'(CODE_LENGTH - 1);
	localparam logic [CW-1:0]   CODE_INIT = CW'(CODE_RESET);

	mode_t               mode_q, mode_d;
	logic [CNTW-1:0]     cnt_q, cnt_d, cnt_inc;
	logic [CW-1:0]       buf_q, buf_d, buf_shift;
	logic [CW-1:0]       code_q, code_d;
	logic [LIMIT_W-1:0]  wrong_q, wrong_d, wrong_inc;
	logic [TICKS_W-1:0]  lock_q, lock_d;
	logic                latch_q, latch_d;
	logic                last;
	status_t             status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENTER;
			cnt_q   <= '0;
			buf_q   <= '0;
			code_q  <= CODE_INIT;
			wrong_q <= '0;
			lock_q  <= '0;
			latch_q <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			buf_q   <= buf_d;
			code_q  <= code_d;
			wrong_q <= wrong_d;
			lock_q  <= lock_d;
			latch_q <= latch_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		buf_d     = buf_q;
		code_d    = code_q;
		wrong_d   = wrong_q;
		lock_d    = lock_q;
		latch_d   = latch_q;
		status    = ST_NONE;
		buf_shift = CW'({buf_q, key});
		last      = (cnt_q == LAST_KEY);
		cnt_inc   = last ? '0 : CNTW'(cnt_q + 1'b1);
		wrong_inc = LIMIT_W'(wrong_q + 1'b1);
		if (command) begin
			if (lock_q != '0) begin
				lock_d = TICKS_W'(lock_q - 1'b1);
			end
		end else if (lock_q == '0) begin
			unique case (mode_q)
				MODE_OPEN: begin
					if (key == KEY_STAR) begin
						latch_d = 1'b0;
						mode_d  = MODE_ENTER;
						status  = ST_RELOCKED;
					end else if (key == KEY_HASH) begin
						latch_d = 1'b0;
						mode_d  = MODE_NEWCODE;
						cnt_d   = '0;
						buf_d   = '0;
						status  = ST_NEWENTRY;
					end
				end
				MODE_NEWCODE: begin
					cnt_d = cnt_inc;
					if (last) begin
						code_d = buf_shift;
						buf_d  = '0;
						mode_d = MODE_ENTER;
						status = ST_CHANGED;
					end else begin
						buf_d  = buf_shift;
						status = ST_TAKEN;
					end
				end
				default: begin
					mode_d = MODE_ENTER;
					cnt_d  = cnt_inc;
					if (last) begin
						buf_d = '0;
						if (buf_shift == code_q) begin
							latch_d = 1'b1;
							mode_d  = MODE_OPEN;
							status  = ST_UNLOCKED;
						end else if (wrong_inc >= cfg.wrong_limit) begin
							wrong_d = '0;
							lock_d  = cfg.lockout_ticks;
							status  = ST_LOCKOUT;
						end else begin
							wrong_d = wrong_inc;
							status  = ST_WRONG;
						end
					end else begin
						buf_d  = buf_shift;
						status = ST_TAKEN;
					end
				end
			endcase
		end
	end

	always_comb begin
		result.status       = status;
		result.latch_open   = latch_d;
		result.keys_entered = KEYS_W'(cnt_d);
		result.locked_out   = (lock_d != '0);
	end

endmodule

// ----- rtl/core/keypad_code_lock.sv -----
// Top level of the keypad code lock with input and result registers.
//
// The lock takes one transaction per clock cycle on the events channel while it is not stalled,
// either a key press or a timer tick, and returns exactly one result transaction for each. A
// transaction accepted on the events channel is held in the input register, evaluated by the
// lock state machine and loaded into the result register once that register is free or its
// result is being taken. With the result side ready the sustained rate is one transaction
// per cycle. While a finished result waits to be taken the input register can still take one
// more transaction; after that the events channel stalls until the result is taken. The stored
// code holds CODE_LENGTH keys and resets to 2 5 8 0. Configuration writes are meant for an idle
// lock and apply to every transaction evaluated after the write.
module keypad_code_lock import klk_pkg::*; #(
	parameter int CODE_LENGTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	klk_in_if.sink                events,
	klk_out_if.source             results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg;
	result_t          result;
	logic             valid_s1;
	logic             command_s1;
	logic [KEY_W-1:0] key_s1;
	logic             valid_s2;
	result_t          result_s2;
	logic             advance;

	klk_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	klk_fsm #(
		.CODE_LENGTH (CODE_LENGTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.command (command_s1),
		.key     (key_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign advance      = valid_s1 && (!valid_s2 || results.ready);
	assign events.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			command_s1 <= events.command;
			key_s1     <= events.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign results.valid        = valid_s2;
	assign results.status       = result_s2.status;
	assign results.latch_open   = result_s2.latch_open;
	assign results.keys_entered = result_s2.keys_entered;
	assign results.locked_out   = result_s2.locked_out;

	a_lockout_closed: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.locked_out |-> !results.latch_open)
		else $error("latch reported open during lockout");

	a_unlock_opens: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == ST_UNLOCKED) |-> results.latch_open)
		else $error("unlock reported without the latch open");

	a_keys_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.keys_entered <= KEYS_W'(CODE_LENGTH - 1)))
		else $error("key count reached the code length");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(command_s1) && $stable(key_s1))
		else $error("input register overwritten before evaluation");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the keypad code lock: directed and random key and tick traffic.
module tb_top;
	import klk_pkg::*;

	localparam logic CMD_KEY   = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam int   CODE_KEYS = 4;
	localparam int   CODE_W    = KEY_W * CODE_KEYS;
	localparam int   MAX_SHOWN = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	klk_in_if  event_ch ();
	klk_out_if result_ch ();

	// Predicted state of the lock and its configuration.
	mode_t              lock_mode     = MODE_ENTER;
	logic [KEYS_W-1:0]  entry_count   = '0;
	logic [CODE_W-1:0]  entry_keys    = '0;
	logic [CODE_W-1:0]  stored_code   = CODE_RESET[CODE_W-1:0];
	logic [LIMIT_W-1:0] wrong_count   = '0;
	logic [LIMIT_W-1:0] wrong_limit   = WRONG_LIMIT_RESET;
	logic [TICKS_W-1:0] lockout_left  = '0;
	logic [TICKS_W-1:0] lockout_ticks = LOCKOUT_TICKS_RESET;
	logic               latch_state   = 1'b0;

	result_t          expected_q[$];
	result_t          oldest;
	logic [KEY_W-1:0] planned_keys[$];
	int               in_idle_pct   = 0;
	int               out_stall_pct = 0;
	logic             hold_rx       = 1'b0;
	int               mismatches    = 0;

	keypad_code_lock u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (event_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic push_key(logic [KEY_W-1:0] k);
		entry_keys  = (entry_keys << KEY_W) | CODE_W'(k);
		entry_count = entry_count + 1'b1;
		if (int'(entry_count) >= CODE_KEYS) begin
			entry_count = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic result_t lock_predict(logic cmd, logic [KEY_W-1:0] k);
		result_t r;
		status_t st;
		st = ST_NONE;
		if (cmd == CMD_TICK) begin
			if (lockout_left != 0)
				lockout_left = lockout_left - 1'b1;
		end else if (lockout_left == 0) begin
			case (lock_mode)
				MODE_OPEN: begin
					if (k == KEY_STAR) begin
						latch_state = 1'b0;
						lock_mode   = MODE_ENTER;
						st          = ST_RELOCKED;
					end else if (k == KEY_HASH) begin
						latch_state = 1'b0;
						lock_mode   = MODE_NEWCODE;
						entry_count = '0;
						entry_keys  = '0;
						st          = ST_NEWENTRY;
					end
				end
				MODE_NEWCODE: begin
					if (push_key(k)) begin
						stored_code = entry_keys;
						entry_keys  = '0;
						lock_mode   = MODE_ENTER;
						st          = ST_CHANGED;
					end else begin
						st = ST_TAKEN;
					end
				end
				default: begin
					lock_mode = MODE_ENTER;
					if (push_key(k)) begin
						if (entry_keys == stored_code) begin
							latch_state = 1'b1;
							lock_mode   = MODE_OPEN;
							st          = ST_UNLOCKED;
						end else begin
							wrong_count = wrong_count + 1'b1;
							st          = ST_WRONG;
							if (wrong_count >= wrong_limit) begin
								wrong_count  = '0;
								lockout_left = lockout_ticks;
								st           = ST_LOCKOUT;
							end
						end
						entry_keys = '0;
					end else begin
						st = ST_TAKEN;
					end
				end
			endcase
		end
		r.status       = st;
		r.latch_open   = latch_state;
		r.keys_entered = entry_count;
		r.locked_out   = (lockout_left != 0);
		return r;
	endfunction

	task automatic send_item(logic cmd, logic [KEY_W-1:0] k);
		while ($urandom_range(99) < in_idle_pct) begin
			event_ch.valid <= 1'b0;
			@(posedge clk);
		end
		event_ch.valid   <= 1'b1;
		event_ch.command <= cmd;
		event_ch.key     <= k;
		@(posedge clk);
		while (!event_ch.ready)
			@(posedge clk);
		expected_q.push_back(lock_predict(cmd, k));
	endtask

	task automatic wait_drain();
		event_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] data;
		data = value;
		if (idx == REG_WRONG_LIMIT)
			data[CFG_DATA_W-1:LIMIT_W] = (CFG_DATA_W - LIMIT_W)'($urandom);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WRONG_LIMIT)
			wrong_limit = data[LIMIT_W-1:0];
		else
			lockout_ticks = data;
	endtask

	task automatic enter_code(logic [CODE_W-1:0] code);
		for (int i = CODE_KEYS - 1; i >= 0; i--)
			send_item(CMD_KEY, code[KEY_W*i +: KEY_W]);
	endtask

	task automatic return_to_entry();
		planned_keys.delete();
		while (lockout_left != 0 || lock_mode != MODE_ENTER || entry_count != 0) begin
			if (lockout_left != 0)
				send_item(CMD_TICK, KEY_W'($urandom_range(15)));
			else if (lock_mode == MODE_OPEN)
				send_item(CMD_KEY, KEY_STAR);
			else
				send_item(CMD_KEY, KEY_W'($urandom_range(9)));
		end
	endtask

	// Mostly complete code entries, right or wrong, with ticks and stray keys mixed in.
	task automatic random_traffic(int count);
		int                roll;
		logic [CODE_W-1:0] plan;
		repeat (count) begin
			roll = $urandom_range(99);
			if (planned_keys.size() != 0) begin
				if (roll < 10)
					send_item(CMD_TICK, KEY_W'($urandom_range(15)));
				else
					send_item(CMD_KEY, planned_keys.pop_front());
			end else if (lockout_left != 0) begin
				if (roll < 75)
					send_item(CMD_TICK, KEY_W'($urandom_range(15)));
				else
					send_item(CMD_KEY, KEY_W'($urandom_range(15)));
			end else if (lock_mode == MODE_OPEN) begin
				if (roll < 35)
					send_item(CMD_KEY, KEY_STAR);
				else if (roll < 60)
					send_item(CMD_KEY, KEY_HASH);
				else if (roll < 85)
					send_item(CMD_KEY, KEY_W'($urandom_range(15)));
				else
					send_item(CMD_TICK, KEY_W'($urandom_range(15)));
			end else if (lock_mode == MODE_ENTER && entry_count == 0 && roll < 80) begin
				plan = (roll < 45) ? stored_code : CODE_W'($urandom);
				for (int i = CODE_KEYS - 1; i >= 0; i--)
					planned_keys.push_back(plan[KEY_W*i +: KEY_W]);
				send_item(CMD_KEY, planned_keys.pop_front());
			end else begin
				if (roll < 85)
					send_item(CMD_KEY, KEY_W'($urandom_range(15)));
				else
					send_item(CMD_TICK, KEY_W'($urandom_range(15)));
			end
		end
	endtask

	task automatic test_open_and_code_change();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		enter_code(16'h2580);
		send_item(CMD_KEY, 4'd7);
		send_item(CMD_TICK, 4'd0);
		send_item(CMD_KEY, KEY_HASH);
		enter_code(16'hFE09);
		enter_code(16'hFE09);
		send_item(CMD_KEY, KEY_STAR);
	endtask

	task automatic test_wrong_entries();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		return_to_entry();
		write_reg(REG_WRONG_LIMIT, 16'd3);
		write_reg(REG_LOCKOUT_TICKS, 16'd2);
		enter_code(stored_code ^ 16'h0001);
		// A correct entry leaves the wrong-entry count as it is.
		enter_code(stored_code);
		send_item(CMD_KEY, KEY_STAR);
		write_reg(REG_WRONG_LIMIT, 16'd1);
		enter_code(stored_code ^ 16'h0100);
		send_item(CMD_KEY, 4'd9);
		send_item(CMD_TICK, 4'd15);
		send_item(CMD_TICK, 4'd0);
		send_item(CMD_KEY, 4'd9);
	endtask

	task automatic test_zero_settings();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		write_reg(REG_WRONG_LIMIT, 16'd0);
		write_reg(REG_LOCKOUT_TICKS, 16'd0);
		return_to_entry();
		enter_code(stored_code ^ 16'h1000);
		send_item(CMD_KEY, 4'd4);
	endtask

	task automatic test_random_traffic();
		write_reg(REG_WRONG_LIMIT, 16'd4);
		write_reg(REG_LOCKOUT_TICKS, 16'd6);
		in_idle_pct   = 0;
		out_stall_pct = 0;
		random_traffic(250);
		write_reg(REG_WRONG_LIMIT, 16'd15);
		write_reg(REG_LOCKOUT_TICKS, 16'd1);
		in_idle_pct   = 79;
		out_stall_pct = 0;
		random_traffic(250);
		write_reg(REG_WRONG_LIMIT, 16'd1);
		write_reg(REG_LOCKOUT_TICKS, 16'd12);
		in_idle_pct   = 0;
		out_stall_pct = 79;
		random_traffic(250);
		write_reg(REG_WRONG_LIMIT, 16'd0);
		write_reg(REG_LOCKOUT_TICKS, CFG_DATA_W'($urandom_range(9)));
		in_idle_pct   = 22;
		out_stall_pct = 22;
		random_traffic(250);
	endtask

	task automatic test_backpressure();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		fork
			begin
				hold_rx = 1'b1;
				repeat (60) @(posedge clk);
				hold_rx = 1'b0;
			end
		join_none
		random_traffic(40);
		wait_drain();
		random_traffic(20);
	endtask

	task automatic test_longest_lockout();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		return_to_entry();
		write_reg(REG_WRONG_LIMIT, 16'd1);
		write_reg(REG_LOCKOUT_TICKS, 16'hFFFF);
		enter_code(stored_code ^ 16'h0001);
		for (int n = 0; n < 48; n++) begin
			if (n % 8 == 0)
				send_item(CMD_KEY, KEY_W'($urandom_range(15)));
			send_item(CMD_TICK, KEY_W'($urandom_range(15)));
		end
		send_item(CMD_KEY, KEY_W'($urandom_range(15)));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("unexpected result transaction: status %0d latch %0b",
							result_ch.status, result_ch.latch_open);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					if (result_ch.status !== oldest.status ||
						result_ch.latch_open !== oldest.latch_open ||
						result_ch.keys_entered !== oldest.keys_entered ||
						result_ch.locked_out !== oldest.locked_out) begin
						if (mismatches < MAX_SHOWN)
							$display({"result mismatch: expected status %0d latch %0b keys %0d ",
								"lockout %0b, got status %0d latch %0b keys %0d lockout %0b"},
								oldest.status, oldest.latch_open, oldest.keys_entered,
								oldest.locked_out, result_ch.status, result_ch.latch_open,
								result_ch.keys_entered, result_ch.locked_out);
						mismatches++;
					end
				end
			end
			if (hold_rx) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= out_stall_pct);
			end
		end
	end

	initial begin
		event_ch.valid   = 1'b0;
		event_ch.command = CMD_KEY;
		event_ch.key     = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_open_and_code_change();
		test_wrong_entries();
		test_zero_settings();
		test_random_traffic();
		test_backpressure();
		test_longest_lockout();
		wait_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("keypad_code_lock verification clean");
		end else begin
			$display("keypad_code_lock verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("keypad_code_lock verification failed");
		$finish;
	end

endmodule
